// ===== rtl/bbc_pkg.sv =====
// bbc_pkg: shared types, bracket codes and the byte decoder for the bracket balance checker
// depends on nothing; used by bbc_core, bbc_out_buf and the top
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned MAX_LINE_BYTES_DEF = 1024;

  localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5b;  // [
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5d;  // ]
  localparam logic [7:0] CH_CURLY_OPEN  = 8'h7b;  // {
  localparam logic [7:0] CH_CURLY_CLOSE = 8'h7d;  // }
  localparam logic [7:0] CH_ANGLE_OPEN  = 8'h3c;  // <
  localparam logic [7:0] CH_ANGLE_CLOSE = 8'h3e;  // >

  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_ANGLE  = 2'd3
  } bracket_kind_t;

  typedef struct packed {
    logic          is_open;
    logic          is_close;
    bracket_kind_t kind;
  } bracket_dec_t;

  // one verdict from the core to the output buffer
  typedef struct packed {
    logic valid;
    logic balanced;
  } result_t;

  function automatic bracket_dec_t decode_byte(input logic [7:0] ch);
    bracket_dec_t d;
    d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    case (ch)
      CH_PAREN_OPEN:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_PAREN_CLOSE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_SQUARE_OPEN:  d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_SQUARE_CLOSE: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CURLY_OPEN:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_CURLY_CLOSE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      CH_ANGLE_OPEN:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      CH_ANGLE_CLOSE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default:         d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/bbc_ram.sv =====
// bbc_ram: generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bbc_core.sv =====
// bbc_core: stack and per-kind counters, one byte per cycle while accept is high
// depends on bbc_pkg and bbc_ram (stack storage)
`timescale 1ns / 1ps

module bbc_core #(
  parameter int unsigned MAX_LINE_BYTES = bbc_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_code,
  input  logic             line_end,
  output bbc_pkg::result_t result
);

  localparam int unsigned DW = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned AW = $clog2(MAX_LINE_BYTES);
  localparam logic [DW-1:0] MAX_CNT = DW'(MAX_LINE_BYTES);

  logic [DW-1:0] depth, depth_next;
  bbc_pkg::bracket_kind_t top, top_next;
  bbc_pkg::bracket_kind_t under, under_eff, under_next;
  logic popped, popped_next;
  logic err, err_next;
  logic [DW-1:0] open_cnt [4];
  logic [DW-1:0] close_cnt [4];
  logic [DW-1:0] open_next [4];
  logic [DW-1:0] close_next [4];

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_rdata;

  bbc_pkg::bracket_dec_t dec;
  logic ok;

  // entry below the top: straight from the ram right after a pop
  assign under_eff = popped ? bbc_pkg::bracket_kind_t'(ram_rdata) : under;

  // prefetch the entry two below the top, needed if this byte pops
  assign ram_raddr = AW'(depth - DW'(3));
  assign ram_waddr = AW'(depth);
  assign dec = bbc_pkg::decode_byte(char_code);

  bbc_ram #(
    .WIDTH(2),
    .DEPTH(MAX_LINE_BYTES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(top_next),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    depth_next  = depth;
    top_next    = top;
    under_next  = under_eff;
    popped_next = 1'b0;
    err_next    = err;
    ram_we      = 1'b0;
    ok          = 1'b0;
    for (int i = 0; i < 4; i++) begin
      open_next[i]  = open_cnt[i];
      close_next[i] = close_cnt[i];
    end

    if (accept && dec.is_open) begin
      if (open_cnt[dec.kind] == MAX_CNT) begin
        err_next = 1'b1;
      end else begin
        open_next[dec.kind] = open_cnt[dec.kind] + DW'(1);
      end
      if (depth == MAX_CNT) begin
        err_next = 1'b1;
      end else begin
        ram_we      = 1'b1;
        top_next    = dec.kind;
        under_next  = top;
        depth_next  = depth + DW'(1);
      end
    end

    if (accept && dec.is_close) begin
      if (close_cnt[dec.kind] == MAX_CNT) begin
        err_next = 1'b1;
      end else begin
        close_next[dec.kind] = close_cnt[dec.kind] + DW'(1);
      end
      if (close_next[dec.kind] > open_cnt[dec.kind]) begin
        err_next = 1'b1;
      end else if (depth == '0 || top != dec.kind) begin
        err_next = 1'b1;
      end else begin
        top_next    = under_eff;
        popped_next = 1'b1;
        depth_next  = depth - DW'(1);
      end
    end

    if (accept && line_end) begin
      ok = !err_next;
      for (int i = 0; i < 4; i++) begin
        if (open_next[i] != close_next[i]) begin
          ok = 1'b0;
        end
      end
      depth_next  = '0;
      popped_next = 1'b0;
      err_next    = 1'b0;
      for (int i = 0; i < 4; i++) begin
        open_next[i]  = '0;
        close_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      popped <= 1'b0;
      err    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        open_cnt[i]  <= '0;
        close_cnt[i] <= '0;
      end
    end else begin
      depth  <= depth_next;
      popped <= popped_next;
      err    <= err_next;
      for (int i = 0; i < 4; i++) begin
        open_cnt[i]  <= open_next[i];
        close_cnt[i] <= close_next[i];
      end
    end
    top   <= top_next;
    under <= under_next;
  end

  assign result.valid    = accept && line_end;
  assign result.balanced = ok;

endmodule

// ===== rtl/bbc_out_buf.sv =====
// bbc_out_buf: two-word output buffer between the core and the master-side stream
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  bbc_pkg::result_t result,
  output logic             space,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata
);

  logic [1:0] count;
  logic       head, tail;
  logic       pop;

  assign pop      = (count != 2'd0) && m_tready;
  assign space    = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = {7'd0, head};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({pop, result.valid})
        2'b01:   count <= count + 2'd1;
        2'b10:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    case ({pop, result.valid})
      2'b01: begin
        if (count == 2'd0) begin
          head <= result.balanced;
        end else begin
          tail <= result.balanced;
        end
      end
      2'b10: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head <= result.balanced;
        end else begin
          head <= tail;
          tail <= result.balanced;
        end
      end
      default: begin
        head <= head;
      end
    endcase
  end

endmodule

// ===== rtl/bracket_balance_checker_top.sv =====
// the verdict for a line is registered in the output buffer when its last byte is accepted
// throughput: one byte per cycle while s_tready is high; the stack ram does a prefetch read
// each cycle and a write per push, with the top and the entry below it held in registers
// reset (rst, synchronous): clears stack depth, counts, error flag and output buffer;
// the stack ram itself is not cleared and needs no clearing pass
`timescale 1ns / 1ps

// top level of the bracket balance checker: byte stream in, one verdict word per line out
// depends on bbc_pkg, bbc_core, bbc_out_buf (and bbc_ram inside the core)

module bracket_balance_checker_top #(
  // bound on stack depth and on each per-kind count
  parameter int unsigned MAX_LINE_BYTES = bbc_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // slave side: bytes of the line
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // line_end, the word that asks for the verdict
  // master side: one verdict word per line
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] balanced, [7:1] zero
);

  bbc_pkg::result_t result;
  logic             space;
  logic             accept;

  // the buffer holds two verdicts, so bytes keep flowing while one waits
  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  // stack and counters, verdict produced in the cycle the last word is taken
  bbc_core #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .char_code(s_tdata),
    .line_end (s_tlast),
    .result   (result)
  );

  // verdict queue toward the master side
  bbc_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .result  (result),
    .space   (space),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

// ===== rtl/bbc_checker.sv =====
// bbc_checker: port-level assertions for the bracket balance checker, bound to the top
// depends on bracket_balance_checker_top (bind target)
`timescale 1ns / 1ps

module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled verdict word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled verdict word changed");

  // nothing left over after reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("verdict word valid right after reset");

  // an empty output side never blocks the input
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with no verdict pending");

  // the last word of a line brings a verdict in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no verdict after end of line");

  // only the balanced bit may be set
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("padding bits set in verdict word");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
